[sv/cmf_pkg.sv]
// Shared types, codes and defaults for the chained multi-queue FIFO.
`timescale 1ns / 1ps

package cmf_pkg;

   localparam int DEFAULT_QUEUE_DEPTH = 16;
   localparam int DEFAULT_QUEUE_COUNT = 5;

   // Operation codes of a request
   typedef enum logic [1:0] {
      OP_ENQUEUE = 2'd0,
      OP_DEQUEUE = 2'd1,
      OP_DISPLAY = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   // Status codes of a response
   typedef enum logic [2:0] {
      ST_DONE   = 3'd0,
      ST_SHOWN  = 3'd1,
      ST_DEPART = 3'd2,
      ST_EMPTY  = 3'd3,
      ST_FULL   = 3'd4
   } status_type;

   typedef struct packed {
      logic [1:0]         operation;
      logic [2:0]         queue_sel;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [31:0] element;
      logic               last;
   } rsp_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EVAL,
      S_DEQ,
      S_SHOW
   } fsm_type;

   // Controller to datapath
   typedef struct packed {
      logic       load;       // capture the request
      logic       snap;       // capture head and fill of the addressed queue
      logic       sel_next;   // look at the queue after the addressed one
      logic       push;       // append to the selected queue
      logic       push_fwd;   // appended word is the read data, not the request value
      logic       pop;        // remove the head of the addressed queue
      logic       rd_start;   // read the head entry
      logic       rd_step;    // read the entry after the current walk position
      logic       emit;       // present a response next cycle
      status_type emit_status;
      logic       emit_elem;  // response element is the read data
      logic       emit_last;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      op_type op;
      logic   q_ok;       // queue number in range
      logic   empty;      // selected queue empty
      logic   full;       // selected queue full
      logic   fwd;        // addressed queue forwards into the next one
      logic   depart;     // addressed queue is the exit queue
      logic   walk_last;  // walk position is the tail of the addressed queue
   } sts_type;

endpackage

[sv/cmf_ctrl.sv]
// Control state machine: sequences enqueue, dequeue and display transactions.
`timescale 1ns / 1ps

module cmf_ctrl
   import cmf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  sts_type sts,
   output cmd_type cmd
);

   fsm_type state_ff;
   fsm_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      cmd.emit_status = ST_DONE;
      busy            = 1'b1;
      case (state_ff)
         S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.snap      = 1'b1;
            cmd.emit_last = 1'b1;
            state_in      = S_IDLE;
            if (!sts.q_ok) begin
               cmd.emit = 1'b1;
            end else begin
               case (sts.op)
                  OP_ENQUEUE: begin
                     cmd.emit = 1'b1;
                     if (sts.full) begin
                        cmd.emit_status = ST_FULL;
                     end else begin
                        cmd.push = 1'b1;
                     end
                  end
                  OP_DEQUEUE: begin
                     if (sts.empty) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = ST_EMPTY;
                     end else begin
                        cmd.rd_start = 1'b1;
                        state_in     = S_DEQ;
                     end
                  end
                  OP_DISPLAY: begin
                     if (sts.empty) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = ST_EMPTY;
                     end else begin
                        cmd.rd_start = 1'b1;
                        state_in     = S_SHOW;
                     end
                  end
                  default: begin
                     cmd.emit = 1'b1;
                  end
               endcase
            end
         end
         S_DEQ: begin
            // head word is in the read register; check room downstream
            cmd.sel_next  = sts.fwd;
            cmd.emit      = 1'b1;
            cmd.emit_last = 1'b1;
            state_in      = S_IDLE;
            if (sts.fwd && sts.full) begin
               cmd.emit_status = ST_FULL;
            end else begin
               cmd.pop = 1'b1;
               if (sts.fwd) begin
                  cmd.push     = 1'b1;
                  cmd.push_fwd = 1'b1;
               end else if (sts.depart) begin
                  cmd.emit_status = ST_DEPART;
                  cmd.emit_elem   = 1'b1;
               end
            end
         end
         S_SHOW: begin
            // one entry per cycle, next read issued alongside
            cmd.emit        = 1'b1;
            cmd.emit_status = ST_SHOWN;
            cmd.emit_elem   = 1'b1;
            cmd.emit_last   = sts.walk_last;
            if (sts.walk_last) begin
               state_in = S_IDLE;
            end else begin
               cmd.rd_step = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

[sv/cmf_datapath.sv]
// Datapath: queue storage, ring pointers, fill counts and response register.
`timescale 1ns / 1ps

module cmf_datapath
   import cmf_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
   parameter int QUEUE_COUNT = DEFAULT_QUEUE_COUNT
) (
   input  logic    clock,
   input  logic    reset,
   input  req_type req_data,
   input  cmd_type cmd,
   output sts_type sts,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int HW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FW = $clog2(QUEUE_DEPTH + 1);
   localparam int QW = $clog2(QUEUE_COUNT);
   localparam int AW = $clog2(QUEUE_COUNT * QUEUE_DEPTH);
   localparam int WORDS = QUEUE_COUNT * QUEUE_DEPTH;

   // Ring position: base plus offset, wrapped once
   function automatic logic [HW-1:0] ring_add(input logic [HW-1:0] base,
                                              input logic [FW-1:0] off);
      logic [FW:0] sum;
      sum = (FW+1)'(base) + (FW+1)'(off);
      if (sum >= (FW+1)'(QUEUE_DEPTH)) begin
         sum = sum - (FW+1)'(QUEUE_DEPTH);
      end
      return sum[HW-1:0];
   endfunction

   // Flat storage address of a queue position
   function automatic logic [AW-1:0] slot(input logic [QW-1:0] qi,
                                          input logic [HW-1:0] pos);
      logic [AW-1:0] row;
      row = AW'(AW'(qi) * AW'(QUEUE_DEPTH));
      return row + AW'(pos);
   endfunction

   req_type       req_ff;
   logic [HW-1:0] head_ff [QUEUE_COUNT];
   logic [HW-1:0] head_in [QUEUE_COUNT];
   logic [FW-1:0] fill_ff [QUEUE_COUNT];
   logic [FW-1:0] fill_in [QUEUE_COUNT];
   logic [HW-1:0] hq_ff;
   logic [FW-1:0] fq_ff;
   logic [FW-1:0] walk_ff;
   logic [31:0]   store_mem [WORDS];
   logic [31:0]   rd_data_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_ff;

   logic          q_ok;
   logic [QW-1:0] q_idx;
   logic [QW-1:0] sel_idx;
   logic [HW-1:0] head_sel;
   logic [FW-1:0] fill_sel;
   logic [HW-1:0] tail_pos;
   logic [FW-1:0] walk_next;
   logic [HW-1:0] rd_base;
   logic [FW-1:0] rd_off;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] wr_addr;
   logic [31:0]   wr_data;

   // Request register
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
   end

   // Queue selection; an out-of-range number looks at queue zero
   assign q_ok     = {1'b0, req_ff.queue_sel} < 4'(QUEUE_COUNT);
   assign q_idx    = q_ok ? req_ff.queue_sel[QW-1:0] : '0;
   assign sel_idx  = cmd.sel_next ? q_idx + QW'(1) : q_idx;
   assign head_sel = head_ff[sel_idx];
   assign fill_sel = fill_ff[sel_idx];
   assign tail_pos = ring_add(head_sel, fill_sel);
   assign walk_next = walk_ff + FW'(1);

   // Status to the controller
   always_comb begin
      sts           = '0;
      sts.op        = op_type'(req_ff.operation);
      sts.q_ok      = q_ok;
      sts.empty     = (fill_sel == '0);
      sts.full      = (fill_sel == FW'(QUEUE_DEPTH));
      sts.fwd       = ({1'b0, req_ff.queue_sel} + 4'd2) < 4'(QUEUE_COUNT);
      sts.depart    = ({1'b0, req_ff.queue_sel} + 4'd1) == 4'(QUEUE_COUNT);
      sts.walk_last = (walk_next == fq_ff);
   end

   // Head and fill updates: pop hits the addressed queue, push the selected one
   always_comb begin
      for (int i = 0; i < QUEUE_COUNT; i++) begin
         head_in[i] = head_ff[i];
         fill_in[i] = fill_ff[i];
         if (cmd.pop && (QW'(i) == q_idx)) begin
            head_in[i] = ring_add(hq_ff, FW'(1));
            fill_in[i] = fq_ff - FW'(1);
         end
         if (cmd.push && (QW'(i) == sel_idx)) begin
            fill_in[i] = fill_sel + FW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < QUEUE_COUNT; i++) begin
            head_ff[i] <= '0;
            fill_ff[i] <= '0;
         end
      end else begin
         head_ff <= head_in;
         fill_ff <= fill_in;
      end
   end

   // Snapshot of the addressed queue and walk position
   always_ff @(posedge clock) begin
      if (cmd.snap) begin
         hq_ff <= head_sel;
         fq_ff <= fill_sel;
      end
      if (cmd.rd_start) begin
         walk_ff <= '0;
      end else if (cmd.rd_step) begin
         walk_ff <= walk_next;
      end
   end

   // Storage ports
   assign rd_base = cmd.rd_start ? head_sel : hq_ff;
   assign rd_off  = cmd.rd_start ? '0 : walk_next;
   assign rd_addr = slot(q_idx, ring_add(rd_base, rd_off));
   assign wr_addr = slot(sel_idx, tail_pos);
   assign wr_data = cmd.push_fwd ? rd_data_ff : req_ff.value;

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         store_mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_start || cmd.rd_step) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff.status  <= cmd.emit_status;
         rsp_ff.element <= cmd.emit_elem ? rd_data_ff : '0;
         rsp_ff.last    <= cmd.emit_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[sv/chained_multi_fifo_top.sv]
// Top level of the chained multi-queue FIFO: controller plus datapath.
`timescale 1ns / 1ps

// QUEUE_COUNT ring queues of QUEUE_DEPTH signed words share one storage array.
// A transaction is taken when start is high and busy low; busy stays high until
// its last response is on the port. Each response is valid for one cycle under
// rsp_valid and must be taken then. An enqueue (stored or refused as full), an
// ignored request and a dequeue or display of an empty queue end in the
// evaluation state. Any other dequeue goes on to the dequeue state (head read
// from the storage array, then the move into the next queue, the drop or the
// departure), also when it is refused because the next queue is full. A display
// walks its entries head to tail, one storage read and one response per cycle.
// Ring pointers and fill counts clear on reset; storage needs no clearing.
module chained_multi_fifo_top
   import cmf_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
   parameter int QUEUE_COUNT = DEFAULT_QUEUE_COUNT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   cmd_type cmd;
   sts_type sts;

   cmf_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   cmf_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .QUEUE_COUNT (QUEUE_COUNT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

[sv/cmf_checker.sv]
// Port-level checks of the chained multi-queue FIFO, bound to the top level.
`timescale 1ns / 1ps

module cmf_checker
   import cmf_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   // An accepted transaction makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transaction did not raise busy");

   // The final response of a transaction shows once the block is free again
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |-> !busy)
      else $error("busy still high with final response");

   // Display entries stream without gaps
   a_stream: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |=> rsp_valid)
      else $error("gap inside a display listing");

   // Responses only follow a busy cycle
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("response without transaction in progress");

   // Element is zero unless a value is shown or departs
   a_elem_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != ST_SHOWN) && (rsp_data.status != ST_DEPART)
         |-> rsp_data.element == '0)
      else $error("nonzero element on a plain status");

endmodule

bind chained_multi_fifo_top cmf_checker u_checker (.*);

[dv/tb_chained_multi_fifo_top.sv]
// Self-checking testbench for the chained multi-queue FIFO top level.
`timescale 1ns / 1ps

module tb_chained_multi_fifo_top;
   import cmf_pkg::*;

   localparam int QD             = DEFAULT_QUEUE_DEPTH;
   localparam int QC             = DEFAULT_QUEUE_COUNT;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 40;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_data;

   // Shadow copy of the rings, kept in step with every accepted transaction
   logic [31:0] ring_word [QC][QD];
   int          ring_head [QC];
   int          ring_fill [QC];

   rsp_type expected_rsp [$];
   int      error_count  = 0;
   int      stall_cycles = 0;

   chained_multi_fifo_top dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic rsp_type make_rsp(input status_type st, input logic [31:0] elem,
                                        input logic is_last);
      rsp_type r;
      r.status  = st;
      r.element = elem;
      r.last    = is_last;
      return r;
   endfunction

   function automatic void append_word(input int q, input logic [31:0] word);
      ring_word[q][(ring_head[q] + ring_fill[q]) % QD] = word;
      ring_fill[q]++;
   endfunction

   // Work out the responses of one accepted transaction and update the rings
   task automatic predict_queue_op(input req_type item);
      int          q;
      logic [31:0] head_word;
      q = item.queue_sel;
      if (q >= QC || item.operation == OP_NONE) begin
         expected_rsp.push_back(make_rsp(ST_DONE, '0, 1'b1));
      end else if (item.operation == OP_ENQUEUE) begin
         if (ring_fill[q] >= QD) begin
            expected_rsp.push_back(make_rsp(ST_FULL, '0, 1'b1));
         end else begin
            append_word(q, item.value);
            expected_rsp.push_back(make_rsp(ST_DONE, '0, 1'b1));
         end
      end else if (item.operation == OP_DEQUEUE) begin
         if (ring_fill[q] == 0) begin
            expected_rsp.push_back(make_rsp(ST_EMPTY, '0, 1'b1));
         end else if (q + 2 < QC && ring_fill[q + 1] >= QD) begin
            // forwarding target full: nothing moves
            expected_rsp.push_back(make_rsp(ST_FULL, '0, 1'b1));
         end else begin
            head_word    = ring_word[q][ring_head[q]];
            ring_head[q] = (ring_head[q] + 1) % QD;
            ring_fill[q]--;
            if (q + 2 < QC) begin
               append_word(q + 1, head_word);
               expected_rsp.push_back(make_rsp(ST_DONE, '0, 1'b1));
            end else if (q + 2 == QC) begin
               expected_rsp.push_back(make_rsp(ST_DONE, '0, 1'b1));
            end else begin
               expected_rsp.push_back(make_rsp(ST_DEPART, head_word, 1'b1));
            end
         end
      end else begin
         // display: head to tail, last flag on the tail only
         if (ring_fill[q] == 0) begin
            expected_rsp.push_back(make_rsp(ST_EMPTY, '0, 1'b1));
         end else begin
            for (int i = 0; i < ring_fill[q]; i++) begin
               expected_rsp.push_back(make_rsp(ST_SHOWN, ring_word[q][(ring_head[q] + i) % QD],
                                               i == ring_fill[q] - 1));
            end
         end
      end
   endtask

   // Drive one transaction after an optional idle gap; returns once it is accepted
   task automatic send_request(input logic [1:0] op, input logic [2:0] qsel,
                               input logic [31:0] val, input int gap);
      req_type item;
      item.operation = op;
      item.queue_sel = qsel;
      item.value     = val;
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start    <= 1'b1;
      req_data <= item;
      while (busy) @(negedge clock);
      @(posedge clock);
      predict_queue_op(item);
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(15))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return 32'h0000_0000;
         3:       return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   // Empty queues, the routing of each queue, extreme values, ignored requests
   task automatic test_empty_and_routing();
      send_request(OP_DISPLAY, 3'd0, 32'h0, 0);
      send_request(OP_DEQUEUE, 3'd0, 32'h0, 0);
      send_request(OP_DEQUEUE, 3'd4, 32'h0, 0);
      send_request(OP_ENQUEUE, 3'd0, 32'h8000_0000, 0);
      send_request(OP_ENQUEUE, 3'd0, 32'h7fff_ffff, 0);
      send_request(OP_ENQUEUE, 3'd0, 32'h0000_0000, 0);
      send_request(OP_ENQUEUE, 3'd0, 32'hffff_ffff, 0);
      send_request(OP_DISPLAY, 3'd0, 32'h0, 0);
      send_request(OP_DEQUEUE, 3'd0, 32'h0, 0);
      send_request(OP_DEQUEUE, 3'd1, 32'h0, 0);
      send_request(OP_DEQUEUE, 3'd2, 32'h0, 0);
      send_request(OP_DISPLAY, 3'd3, 32'h0, 0);
      send_request(OP_DEQUEUE, 3'd3, 32'h0, 0);
      send_request(OP_DISPLAY, 3'd3, 32'h0, 0);
      send_request(OP_ENQUEUE, 3'd4, 32'h8000_0000, 0);
      send_request(OP_ENQUEUE, 3'd4, 32'h7fff_ffff, 0);
      send_request(OP_DEQUEUE, 3'd4, 32'h0, 0);
      send_request(OP_DEQUEUE, 3'd4, 32'h0, 0);
      send_request(OP_NONE,    3'd2, 32'hffff_ffff, 0);
      send_request(OP_ENQUEUE, 3'd5, 32'h1234_5678, 0);
      send_request(OP_DISPLAY, 3'd7, 32'h0, 0);
      send_request(OP_DEQUEUE, 3'd6, 32'h0, 0);
      send_request(OP_DISPLAY, 3'd1, 32'h0, 0);
   endtask

   // Full queues: enqueue into full, dequeue blocked by a full next queue,
   // a full display, and a drop that ignores the full exit queue
   task automatic test_full_queues();
      while (ring_fill[1] < QD) send_request(OP_ENQUEUE, 3'd1, pick_value(), 0);
      send_request(OP_ENQUEUE, 3'd1, pick_value(), 0);
      send_request(OP_ENQUEUE, 3'd0, pick_value(), 0);
      send_request(OP_DEQUEUE, 3'd0, 32'h0, 0);
      send_request(OP_DISPLAY, 3'd1, 32'h0, 0);
      while (ring_fill[4] < QD) send_request(OP_ENQUEUE, 3'd4, pick_value(), 0);
      send_request(OP_ENQUEUE, 3'd3, pick_value(), 0);
      send_request(OP_DEQUEUE, 3'd3, 32'h0, 0);
      send_request(OP_DISPLAY, 3'd4, 32'h0, 0);
      while (ring_fill[4] > 0) send_request(OP_DEQUEUE, 3'd4, 32'h0, 0);
      send_request(OP_DEQUEUE, 3'd4, 32'h0, 0);
   endtask

   // Random mix; enq_pct steers the fill levels, idle_pct the sender gaps
   task automatic test_random_traffic(input int count, input int idle_pct, input int enq_pct);
      int         done_items;
      int         pick;
      int         gap;
      bit         burst;
      logic [1:0] op;
      logic [2:0] qsel;
      done_items = 0;
      burst      = 1'b0;
      while (done_items < count) begin
         if (done_items % 16 == 0) burst = ($urandom_range(3) == 0);
         gap = 0;
         if (!burst && $urandom_range(99) < idle_pct) gap = $urandom_range(1, 6);
         pick = $urandom_range(99);
         qsel = 3'($urandom_range(0, QC - 1));
         if (pick < 6) begin
            // ignored request: bad queue number or the spare operation code
            if ($urandom_range(1)) begin
               op   = 2'($urandom_range(0, 3));
               qsel = 3'($urandom_range(QC, 7));
            end else begin
               op = OP_NONE;
            end
         end else begin
            pick = $urandom_range(99);
            if (pick < enq_pct) op = OP_ENQUEUE;
            else if (pick < enq_pct + 12) op = OP_DISPLAY;
            else op = OP_DEQUEUE;
            done_items++;
         end
         send_request(op, qsel, pick_value(), gap);
      end
   endtask

   // Compare each response with the oldest expectation
   always @(posedge clock) begin : check_responses
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_rsp.size() == 0) begin
            $error("unexpected response: status %0d element %0d last %0d",
                   rsp_data.status, rsp_data.element, rsp_data.last);
            error_count++;
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_data.status);
               error_count++;
            end
            if (rsp_data.element !== want.element) begin
               $error("element: expected %0d, actual %0d", want.element, rsp_data.element);
               error_count++;
            end
            if (rsp_data.last !== want.last) begin
               $error("last: expected %0d, actual %0d", want.last, rsp_data.last);
               error_count++;
            end
         end
      end
   end

   // Watchdog on cycles with neither a request nor a response taken
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_and_routing();
      test_full_queues();
      test_random_traffic(120, 0, 50);
      test_random_traffic(120, 72, 35);
      test_random_traffic(120, 10, 60);

      @(negedge clock);
      start <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && expected_rsp.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
